// File: rtl/core/nsm_pkg.sv
// ----------------------------------------------------------------------------
// N-gram suffix match drafter package
// Shared constants, codes and types of the suffix match drafter.
// ----------------------------------------------------------------------------
package nsm_pkg;

  localparam int HISTORY_DEPTH = 4096;
  localparam int MAX_NGRAM     = 8;
  localparam int TOKEN_BITS    = 18;

  localparam int POS_BITS      = 12;
  localparam int LEN_BITS      = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 18;
  localparam int ADDR_BITS     = $clog2(HISTORY_DEPTH);
  localparam int WIN_SIZE      = MAX_NGRAM + 1;
  localparam int LDC_BITS      = $clog2(MAX_NGRAM + 1);
  localparam int SUF_IDX_BITS  = $clog2(MAX_NGRAM);

  typedef logic [TOKEN_BITS-1:0] tok_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [LEN_BITS-1:0]   len_t;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_MATCH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_MATCH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_END_TOKEN = 2'd2;

  localparam len_t MIN_MATCH_RST = 4'd3;
  localparam len_t MAX_MATCH_RST = 4'd8;
  localparam tok_t END_TOKEN_RST = 18'd2;

  typedef struct packed {
    logic  en;
    logic  we;
    addr_t addr;
    tok_t  wdata;
  } ram_req_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
  } win_ctl_t;

  typedef struct packed {
    logic                 empty;
    logic [MAX_NGRAM:1]   found;
    tok_t [MAX_NGRAM:1]   draft;
  } win_res_t;

endpackage

// File: rtl/core/ngram_suffix_match_drafter.sv
// ----------------------------------------------------------------------------
// N-gram suffix match drafter
// Stores each request's token in the history and drafts the token that
// followed the most recent earlier copy of the longest history suffix.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel carries a position and a token. The token
// is written to the history at that position, and the history then ends
// there. One result follows each request on the output channel: the found
// flag, the draft token, the match length and the end flag.
// The configuration channel sets the shortest and longest match lengths and
// the end token; it is always ready, and the user must write it only while
// the block is idle; the block itself does not enforce this. After a request
// is accepted its token is written, and the history is then read once per
// cycle on its single RAM port, from the new position down to slot zero,
// while one window comparator checks all lengths for each slot. A new request
// is taken in the cycle after its predecessor's result is loaded into
// the output register, so requests are processed one at a time. A result that
// the receiver stalls is held in the output register while the next request
// is processed; that request's result waits until the register is free.
// Reset restores the register defaults and empties the pipeline; history
// contents are undefined until written.
// ----------------------------------------------------------------------------
module ngram_suffix_match_drafter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [nsm_pkg::POS_BITS-1:0]      position_i,
  input  logic [nsm_pkg::TOKEN_BITS-1:0]    token_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [nsm_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [nsm_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              found_o,
  output logic [nsm_pkg::TOKEN_BITS-1:0]    draft_token_o,
  output logic [nsm_pkg::LEN_BITS-1:0]      match_length_o,
  output logic                              is_end_o
);
  import nsm_pkg::*;

  ram_req_t ram_req;
  tok_t     ram_rdata;
  win_ctl_t win_ctl;
  win_res_t win_res;

  nsm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .position_i     (position_i),
    .token_i        (token_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .draft_token_o  (draft_token_o),
    .match_length_o (match_length_o),
    .is_end_o       (is_end_o),
    .ram_req_o      (ram_req),
    .win_ctl_o      (win_ctl),
    .win_res_i      (win_res)
  );

  nsm_ram #(
    .WIDTH (TOKEN_BITS),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .en_i    (ram_req.en),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  nsm_match u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (win_ctl),
    .rdata_i (ram_rdata),
    .res_o   (win_res)
  );

endmodule

// File: rtl/core/nsm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or one write per cycle, with registered read data.
// ----------------------------------------------------------------------------
module nsm_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/nsm_match.sv
// ----------------------------------------------------------------------------
// Suffix window comparator
// Slides a window down the history and records, for every match length,
// the token after the most recent occurrence of the current suffix.
// ----------------------------------------------------------------------------
module nsm_match (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nsm_pkg::win_ctl_t ctl_i,
  input  nsm_pkg::tok_t     rdata_i,
  output nsm_pkg::win_res_t res_o
);
  import nsm_pkg::*;

  tok_t                win_q [WIN_SIZE];
  logic [WIN_SIZE-1:0] vld_q;
  tok_t                suf_q [MAX_NGRAM];
  logic [LDC_BITS-1:0] ld_cnt_q;
  logic [MAX_NGRAM:1]  fnd_q;
  tok_t                drf_q [1:MAX_NGRAM];

  logic [MAX_NGRAM-1:0] eq;
  logic [MAX_NGRAM:1]   hit;
  logic                 run;
  logic                 suf_we;

  assign suf_we = ctl_i.load && (ld_cnt_q < LDC_BITS'(MAX_NGRAM));

  // Entry k+1 of the window is compared with suffix token k.
  always_comb begin
    run = vld_q[0];
    for (int k = 0; k < MAX_NGRAM; k++) begin
      eq[k] = (win_q[k+1] == suf_q[k]);
    end
    for (int n = 1; n <= MAX_NGRAM; n++) begin
      run    = run & eq[n-1];
      hit[n] = run & vld_q[n];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      ld_cnt_q <= '0;
      fnd_q    <= '0;
    end else if (ctl_i.clear) begin
      vld_q    <= '0;
      ld_cnt_q <= '0;
      fnd_q    <= '0;
    end else begin
      if (ctl_i.shift) begin
        vld_q <= {ctl_i.load, vld_q[WIN_SIZE-1:1]};
      end
      if (suf_we) begin
        ld_cnt_q <= ld_cnt_q + LDC_BITS'(1);
      end
      fnd_q <= fnd_q | hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      for (int j = 0; j < WIN_SIZE - 1; j++) begin
        win_q[j] <= win_q[j+1];
      end
      win_q[WIN_SIZE-1] <= rdata_i;
    end
    if (suf_we) begin
      suf_q[ld_cnt_q[SUF_IDX_BITS-1:0]] <= rdata_i;
    end
    for (int n = 1; n <= MAX_NGRAM; n++) begin
      if (hit[n] && !fnd_q[n]) begin
        drf_q[n] <= win_q[0];
      end
    end
  end

  always_comb begin
    res_o.empty = ~|vld_q;
    res_o.found = fnd_q;
    for (int n = 1; n <= MAX_NGRAM; n++) begin
      res_o.draft[n] = drf_q[n];
    end
  end

endmodule

// File: rtl/core/nsm_ctrl.sv
// ----------------------------------------------------------------------------
// Drafter sequencer
// Holds the configuration, writes the new token, sweeps the history
// addresses downward and picks the longest qualifying match.
// ----------------------------------------------------------------------------
module nsm_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [nsm_pkg::POS_BITS-1:0]         position_i,
  input  nsm_pkg::tok_t                        token_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [nsm_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [nsm_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 found_o,
  output nsm_pkg::tok_t                        draft_token_o,
  output nsm_pkg::len_t                        match_length_o,
  output logic                                 is_end_o,
  output nsm_pkg::ram_req_t                    ram_req_o,
  output nsm_pkg::win_ctl_t                    win_ctl_o,
  input  nsm_pkg::win_res_t                    win_res_i
);
  import nsm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WRITE  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  addr_t  pos_q;
  tok_t   tok_q;
  len_t   lo_q, hi_q;
  len_t   lo_d, hi_d;
  addr_t  addr_q;
  logic   rd_done_q, dvalid_q;
  len_t   min_q, max_q;
  tok_t   end_q;
  logic   out_valid_q;
  logic   found_q, is_end_q;
  tok_t   draft_q;
  len_t   mlen_q;

  logic   in_acc, rd_issue, scan, scan_end, out_free, out_load;
  logic   sel_found;
  len_t   sel_len;
  tok_t   sel_tok;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign scan        = (state_q == ST_SCAN);
  assign rd_issue    = scan && !rd_done_q;
  assign scan_end    = scan && rd_done_q && !dvalid_q && win_res_i.empty;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = (state_q == ST_FINISH) && out_free;

  always_comb begin
    lo_d = (min_q == '0) ? LEN_BITS'(1) : min_q;
    hi_d = max_q;
    if (hi_d > LEN_BITS'(MAX_NGRAM)) begin
      hi_d = LEN_BITS'(MAX_NGRAM);
    end
    if (POS_BITS'(hi_d) > position_i) begin
      hi_d = position_i[LEN_BITS-1:0];
    end
  end

  always_comb begin
    ram_req_o.en    = (state_q == ST_WRITE) || rd_issue;
    ram_req_o.we    = (state_q == ST_WRITE);
    ram_req_o.addr  = (state_q == ST_WRITE) ? pos_q : addr_q;
    ram_req_o.wdata = tok_q;
    win_ctl_o.clear = in_acc;
    win_ctl_o.shift = scan && (dvalid_q || rd_done_q);
    win_ctl_o.load  = dvalid_q;
  end

  // The highest qualifying length wins.
  always_comb begin
    sel_found = 1'b0;
    sel_len   = '0;
    sel_tok   = '0;
    for (int n = 1; n <= MAX_NGRAM; n++) begin
      if (win_res_i.found[n] && (LEN_BITS'(n) >= lo_q) && (LEN_BITS'(n) <= hi_q)) begin
        sel_found = 1'b1;
        sel_len   = LEN_BITS'(n);
        sel_tok   = win_res_i.draft[n];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_done_q   <= 1'b0;
      dvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      min_q       <= MIN_MATCH_RST;
      max_q       <= MAX_MATCH_RST;
      end_q       <= END_TOKEN_RST;
    end else begin
      state_q  <= state_d;
      dvalid_q <= rd_issue;
      if (in_acc) begin
        rd_done_q <= 1'b0;
      end else if (rd_issue && (addr_q == '0)) begin
        rd_done_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MIN_MATCH: min_q <= cfg_data_i[LEN_BITS-1:0];
          CFG_MAX_MATCH: max_q <= cfg_data_i[LEN_BITS-1:0];
          CFG_END_TOKEN: end_q <= cfg_data_i[TOKEN_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q <= position_i[ADDR_BITS-1:0];
      tok_q <= token_i;
      lo_q  <= lo_d;
      hi_q  <= hi_d;
    end
    if (state_q == ST_WRITE) begin
      addr_q <= pos_q;
    end else if (rd_issue) begin
      addr_q <= addr_q - ADDR_BITS'(1);
    end
    if (out_load) begin
      found_q  <= sel_found;
      draft_q  <= sel_tok;
      mlen_q   <= sel_len;
      is_end_q <= sel_found && (sel_tok == end_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign draft_token_o  = draft_q;
  assign match_length_o = mlen_q;
  assign is_end_o       = is_end_q;

endmodule

// File: rtl/core/nsm_checker.sv
// ----------------------------------------------------------------------------
// N-gram suffix match drafter checker
// Port-level properties of the drafter, bound to the top level.
// ----------------------------------------------------------------------------
module nsm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              found_o,
  input logic [nsm_pkg::TOKEN_BITS-1:0]    draft_token_o,
  input logic [nsm_pkg::LEN_BITS-1:0]      match_length_o,
  input logic                              is_end_o
);
  import nsm_pkg::*;

  // A stalled result keeps its valid and its fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) &&
      $stable(draft_token_o) && $stable(match_length_o) && $stable(is_end_o))
    else $error("stalled result changed");

  // Ready drops after an accepted request, since the drafter is then busy with it.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("drafter ready right after a request");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> draft_token_o == '0 && match_length_o == '0 && !is_end_o)
    else $error("miss result has nonzero fields");

  a_hit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> match_length_o != '0 &&
      match_length_o <= LEN_BITS'(MAX_NGRAM))
    else $error("match length out of range");

endmodule

bind ngram_suffix_match_drafter nsm_checker u_nsm_checker (.*);
